// ===== rtl/core/u8d_pkg.sv =====
// Package for the UTF-8 stream decoder: byte token types, result kinds and
// shared constants. Used by every module of the decoder.
`default_nettype none

package u8d_pkg;

    localparam int COUNT_BITS = 32;
    localparam int OUT_COUNT_BITS = 32;
    localparam int CP_BITS = 21;
    localparam int ACC_BITS = 31;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int WIDE_COUNT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_BAD = 2'd2;

    localparam logic [CP_BITS-1:0] CP_LIMIT_RESET = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [ACC_BITS-1:0] CP_MAX = 31'h0010FFFF;
    localparam logic [ACC_BITS-1:0] SURR_LO = 31'h0000D800;
    localparam logic [ACC_BITS-1:0] SURR_HI = 31'h0000DFFF;
    localparam logic [ACC_BITS-1:0] NONCHAR_LO = 31'h0000FFFE;
    localparam logic [ACC_BITS-1:0] NONCHAR_HI = 31'h0000FFFF;

    typedef enum logic [2:0] {
        TK_NUL,
        TK_ASCII,
        TK_CONT,
        TK_LEAD,
        TK_BADLEAD
    } tok_cls_t;

    typedef struct packed {
        tok_cls_t cls;
        logic [2:0] len;
        logic [6:0] data;
    } tok_t;

    function automatic logic [OUT_COUNT_BITS-1:0] sat_count(
        input logic [COUNT_BITS-1:0] cnt
    );
        logic [WIDE_COUNT_BITS-1:0] wide;
        wide = WIDE_COUNT_BITS'(cnt);
        if (wide > WIDE_COUNT_BITS'({OUT_COUNT_BITS{1'b1}}))
        begin
            return '1;
        end
        return wide[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u8d_front.sv =====
// Front end of the UTF-8 decoder: accepts raw bytes and classifies each one
// into a token for the queue. Depends on u8d_pkg.
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic       in_valid,
    input  wire logic [7:0] text_byte,
    input  wire logic       queue_full,
    output logic            in_stall,
    output logic            push,
    output tok_t            push_tok
);

    assign in_stall = queue_full;
    assign push = in_valid && !queue_full;

    always_comb
    begin
        push_tok.cls = TK_BADLEAD;
        push_tok.len = 3'd0;
        push_tok.data = text_byte[6:0];
        if (text_byte == 8'h00)
        begin
            push_tok.cls = TK_NUL;
        end
        else if (!text_byte[7])
        begin
            push_tok.cls = TK_ASCII;
        end
        else if (!text_byte[6])
        begin
            push_tok.cls = TK_CONT;
            push_tok.data = {1'b0, text_byte[5:0]};
        end
        else if (!text_byte[5])
        begin
            push_tok.cls = TK_LEAD;
            push_tok.len = 3'd1;
            push_tok.data = {2'b0, text_byte[4:0]};
        end
        else if (!text_byte[4])
        begin
            push_tok.cls = TK_LEAD;
            push_tok.len = 3'd2;
            push_tok.data = {3'b0, text_byte[3:0]};
        end
        else if (!text_byte[3])
        begin
            push_tok.cls = TK_LEAD;
            push_tok.len = 3'd3;
            push_tok.data = {4'b0, text_byte[2:0]};
        end
        else if (!text_byte[2])
        begin
            push_tok.cls = TK_LEAD;
            push_tok.len = 3'd4;
            push_tok.data = {5'b0, text_byte[1:0]};
        end
        else if (!text_byte[1])
        begin
            push_tok.cls = TK_LEAD;
            push_tok.len = 3'd5;
            push_tok.data = {6'b0, text_byte[0]};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8d_queue.sv =====
// Short token queue between the front end and the decode back end of the
// UTF-8 decoder. Depends on u8d_pkg.
`default_nettype none

module u8d_queue
    import u8d_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  tok_t      push_tok,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output tok_t      head_tok
);

    tok_t slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0] count_reg;
    logic [QUEUE_PTR_BITS:0] count_next;

    assign full = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_tok = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8d_back.sv =====
// Decode back end of the UTF-8 decoder: runs the character state machine on
// queued tokens and holds the result register. Depends on u8d_pkg.
`default_nettype none

module u8d_back
    import u8d_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CP_BITS-1:0]        cfg_wr_data,
    input  wire logic                      tok_valid,
    input  tok_t                           tok,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     kind,
    output logic [CP_BITS-1:0]             codepoint,
    output logic [OUT_COUNT_BITS-1:0]      char_count
);

    logic [CP_BITS-1:0] limit_reg;
    logic [2:0] left_reg;
    logic [2:0] left_next;
    logic [ACC_BITS-1:0] acc_reg;
    logic [ACC_BITS-1:0] acc_next;
    logic [ACC_BITS-1:0] acc_shift;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic skip_reg;
    logic skip_next;
    logic out_valid_reg;
    logic [1:0] kind_reg;
    logic [CP_BITS-1:0] cp_reg;
    logic [OUT_COUNT_BITS-1:0] count_out_reg;

    logic res_valid;
    logic [1:0] res_kind;
    logic [CP_BITS-1:0] res_cp;
    logic [OUT_COUNT_BITS-1:0] res_cnt;
    logic err;
    logic err_at_nul;
    logic fin;
    logic [ACC_BITS-1:0] fin_cp;
    logic cp_bad;

    assign pop = tok_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign codepoint = cp_reg;
    assign char_count = count_out_reg;
    assign acc_shift = {acc_reg[ACC_BITS-7:0], tok.data[5:0]};

    always_comb
    begin
        left_next = left_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        skip_next = skip_reg;
        res_valid = 1'b0;
        res_kind = KIND_CHAR;
        res_cp = '0;
        res_cnt = '0;
        err = 1'b0;
        err_at_nul = 1'b0;
        fin = 1'b0;
        fin_cp = '0;
        if (pop)
        begin
            if (skip_reg)
            begin
                if (tok.cls == TK_NUL)
                begin
                    skip_next = 1'b0;
                end
            end
            else if (left_reg != 3'd0)
            begin
                if (tok.cls != TK_CONT)
                begin
                    err = 1'b1;
                    err_at_nul = (tok.cls == TK_NUL);
                end
                else
                begin
                    acc_next = acc_shift;
                    left_next = left_reg - 3'd1;
                    if (left_reg == 3'd1)
                    begin
                        fin = 1'b1;
                        fin_cp = acc_shift;
                    end
                end
            end
            else
            begin
                case (tok.cls)
                    TK_NUL:
                    begin
                        res_valid = 1'b1;
                        res_kind = KIND_END;
                        res_cnt = sat_count(cnt_reg);
                        cnt_next = '0;
                    end
                    TK_ASCII:
                    begin
                        fin = 1'b1;
                        fin_cp = ACC_BITS'(tok.data);
                    end
                    TK_LEAD:
                    begin
                        acc_next = ACC_BITS'(tok.data);
                        left_next = tok.len;
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase
            end
        end

        cp_bad = (fin_cp >= SURR_LO && fin_cp <= SURR_HI)
            || (fin_cp >= NONCHAR_LO && fin_cp <= NONCHAR_HI)
            || (fin_cp > CP_MAX);

        if (fin)
        begin
            left_next = 3'd0;
            acc_next = '0;
            if (cp_bad)
            begin
                err = 1'b1;
            end
            else
            begin
                res_valid = 1'b1;
                res_kind = KIND_CHAR;
                res_cp = (fin_cp > ACC_BITS'(limit_reg)) ? CP_REPLACEMENT
                                                         : fin_cp[CP_BITS-1:0];
                if (cnt_reg != {COUNT_BITS{1'b1}})
                begin
                    cnt_next = cnt_reg + COUNT_BITS'(1);
                end
            end
        end

        if (err)
        begin
            left_next = 3'd0;
            acc_next = '0;
            cnt_next = '0;
            skip_next = !err_at_nul;
            res_valid = 1'b1;
            res_kind = KIND_BAD;
            res_cp = '0;
            res_cnt = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_valid)
        begin
            kind_reg <= res_kind;
            cp_reg <= res_cp;
            count_out_reg <= res_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CP_LIMIT_RESET;
            left_reg <= 3'd0;
            acc_reg <= '0;
            cnt_reg <= '0;
            skip_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            left_reg <= left_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            skip_reg <= skip_next;
            if (pop)
            begin
                out_valid_reg <= res_valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_skip_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (left_reg == 3'd0))
        else $error("Skipping while inside a character.");

    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'd5)
        else $error("Continuation count out of range.");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !skip_reg && (left_reg == 3'd0) && (tok.cls == TK_NUL))
        |=> (cnt_reg == '0))
        else $error("String end did not clear the count.");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_CHAR))
        |-> ((cp_reg <= CP_MAX[CP_BITS-1:0])
            && !(cp_reg >= SURR_LO[CP_BITS-1:0] && cp_reg <= SURR_HI[CP_BITS-1:0])))
        else $error("Illegal codepoint delivered.");

    a_side_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_CHAR)) |-> (cp_reg == '0))
        else $error("Codepoint not zero on a non-character result.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: byte classifier, token queue and
// decode back end. Depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.
//
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   text_byte
// output    out        out_valid/out_stall kind, codepoint, char_count
// config    in         cfg_wr_en           cfg_wr_data (replace_above)
//
// One byte is accepted per cycle while the token queue is not full.
// The decode state update takes one token per cycle unless output stalls.
// Reset clears the decode state and sets the limit to 0x10FFFF.
// A four-entry token queue absorbs output stalls; input stalls only when full.
`default_nettype none

module utf8_stream_decoder_top
    import u8d_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CP_BITS-1:0]        cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                text_byte,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     kind,
    output logic [CP_BITS-1:0]             codepoint,
    output logic [OUT_COUNT_BITS-1:0]      char_count
);

    logic push;
    tok_t push_tok;
    logic queue_full;
    logic queue_not_empty;
    tok_t head_tok;
    logic pop;

    u8d_front u_front (
        .in_valid   (in_valid),
        .text_byte  (text_byte),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_tok   (push_tok)
    );

    u8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_tok   (push_tok),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_not_empty),
        .head_tok   (head_tok)
    );

    u8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tok_valid   (queue_not_empty),
        .tok         (head_tok),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .codepoint   (codepoint),
        .char_count  (char_count)
    );

endmodule

`default_nettype wire

// ===== sim/utf8_stream_decoder_top_test.sv =====
// Self-checking testbench for utf8_stream_decoder_top: directed and random UTF-8 text
// under several replacement limits, with random gaps and output stalls.
// Depends on u8d_pkg and the decoder RTL only.
module utf8_stream_decoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES = 215;

    typedef logic [7:0] text_q_t[$];

    typedef struct {
        logic [1:0] kind;
        logic [CP_BITS-1:0] codepoint;
        logic [OUT_COUNT_BITS-1:0] char_count;
    } decoded_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CP_BITS-1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic [7:0] text_byte;
    logic out_valid;
    logic out_stall;
    logic [1:0] kind;
    logic [CP_BITS-1:0] codepoint;
    logic [OUT_COUNT_BITS-1:0] char_count;

    decoded_t pending_results[$];

    logic [2:0] cont_left;
    logic [ACC_BITS-1:0] partial_cp;
    logic [COUNT_BITS-1:0] char_total;
    bit skip_to_nul;
    logic [CP_BITS-1:0] cp_limit;

    bit idle_on;
    bit quiet;
    int stall_left;
    int idle_cycles;
    int bytes_taken;
    int error_count;
    int chars_seen;
    int ends_seen;
    int bad_seen;
    int limits_written;

    utf8_stream_decoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .codepoint   (codepoint),
        .char_count  (char_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic void push_result(
        input logic [1:0] k,
        input logic [CP_BITS-1:0] cp,
        input logic [OUT_COUNT_BITS-1:0] cnt
    );
        decoded_t r;
        r.kind = k;
        r.codepoint = cp;
        r.char_count = cnt;
        pending_results.push_back(r);
    endfunction

    function automatic void reject_string(input bit at_nul);
        cont_left = '0;
        partial_cp = '0;
        char_total = '0;
        skip_to_nul = !at_nul;
        push_result(KIND_BAD, '0, '0);
    endfunction

    function automatic void complete_char(input logic [ACC_BITS-1:0] v);
        cont_left = '0;
        partial_cp = '0;
        if ((v >= SURR_LO && v <= SURR_HI) || (v >= NONCHAR_LO && v <= NONCHAR_HI)
            || v > CP_MAX)
        begin
            reject_string(1'b0);
        end
        else
        begin
            if (char_total != '1)
            begin
                char_total = char_total + 1'b1;
            end
            push_result(KIND_CHAR, (v > ACC_BITS'(cp_limit)) ? CP_REPLACEMENT
                        : v[CP_BITS-1:0], '0);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int len;
        logic [7:0] mask;
        logic [63:0] wide;
        if (skip_to_nul)
        begin
            if (b == 8'h00)
            begin
                skip_to_nul = 1'b0;
            end
            return;
        end
        if (cont_left != 0)
        begin
            if (b[7:6] != 2'b10)
            begin
                reject_string(b == 8'h00);
                return;
            end
            partial_cp = {partial_cp[ACC_BITS-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0)
            begin
                complete_char(partial_cp);
            end
            return;
        end
        if (b == 8'h00)
        begin
            wide = 64'(char_total);
            char_total = '0;
            push_result(KIND_END, '0, (wide > 64'(32'hFFFF_FFFF)) ? '1
                        : wide[OUT_COUNT_BITS-1:0]);
            return;
        end
        if (b <= 8'h7F)
        begin
            complete_char(ACC_BITS'(b));
            return;
        end
        len = 0;
        while (len < 8 && b[7 - len])
        begin
            len++;
        end
        if (len < 2 || len > 6)
        begin
            reject_string(1'b0);
            return;
        end
        mask = 8'hFF >> (len + 1);
        partial_cp = ACC_BITS'(b & mask);
        cont_left = 3'(len - 1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result();
        decoded_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("unrequested result kind %0d", kind));
            return;
        end
        want = pending_results.pop_front();
        if (kind != want.kind)
        begin
            report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
        end
        if (codepoint != want.codepoint)
        begin
            report_mismatch($sformatf("codepoint %h, wanted %h", codepoint, want.codepoint));
        end
        if (char_count != want.char_count)
        begin
            report_mismatch($sformatf("char_count %0d, wanted %0d", char_count,
                                      want.char_count));
        end
        case (want.kind)
            KIND_CHAR: chars_seen++;
            KIND_END: ends_seen++;
            default: bad_seen++;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (out_valid && !out_stall)
            begin
                idle_cycles = 0;
                check_result();
            end
            if (in_valid && !in_stall)
            begin
                idle_cycles = 0;
                bytes_taken++;
                decode_byte(text_byte);
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding.",
                         pending_results.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid)
            begin
                stall_left = idle_on ? $urandom_range(0, 11) : 0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        text_byte <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_text(input text_q_t s);
        foreach (s[i])
        begin
            send_byte(s[i]);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        quiet = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        quiet = 1'b0;
    endtask

    task automatic write_limit(input logic [CP_BITS-1:0] v);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cp_limit = v;
        limits_written++;
    endtask

    task automatic send_wide_char(input int len);
        logic [7:0] lead;
        lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
        send_byte(lead);
        repeat (len - 1) send_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    task automatic send_random_char();
        int pick;
        logic [7:0] lead;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            send_byte(8'($urandom));
        end
        else if (pick < 11)
        begin
            send_byte(8'hC0 | 8'($urandom_range(0, 31)));
            if ($urandom_range(0, 3) == 0)
            begin
                b = 8'h00;
            end
            else
            begin
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                begin
                    b[7] = 1'b0;
                end
            end
            send_byte(b);
        end
        else if (pick < 14)
        begin
            case ($urandom_range(0, 2))
                0: send_byte(8'h80 | 8'($urandom_range(0, 63)));
                1: send_byte(8'hFE);
                default: send_byte(8'hFF);
            endcase
        end
        else if (pick < 50)
        begin
            send_byte(8'($urandom_range(1, 127)));
        end
        else if (pick < 68)
        begin
            send_wide_char(2);
        end
        else if (pick < 84)
        begin
            send_wide_char(3);
        end
        else if (pick < 94)
        begin
            lead = 8'hF0 | 8'($urandom_range(0, 4));
            send_byte(lead);
            send_byte(8'h80 | 8'((lead == 8'hF4) ? $urandom_range(0, 15)
                                 : $urandom_range(0, 63)));
            send_byte(8'h80 | 8'($urandom_range(0, 63)));
            send_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
        else
        begin
            send_wide_char($urandom_range(4, 6));
        end
    endtask

    task automatic send_random_string();
        int n;
        n = $urandom_range(0, 12);
        repeat (n) send_random_char();
        send_byte(8'h00);
    endtask

    task automatic test_legal_forms();
        send_text('{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80,
                    8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFC, 8'h80, 8'h80, 8'h80, 8'h80,
                    8'h81, 8'h00, 8'h00});
        settle();
    endtask

    task automatic test_error_forms();
        send_text('{8'h80, 8'h41, 8'h00, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'hC2, 8'h41,
                    8'h00, 8'hC2, 8'h00, 8'hED, 8'hA0, 8'h80, 8'h00, 8'hEF, 8'hBF,
                    8'hBE, 8'h00, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h00, 8'h41, 8'h00});
        settle();
    endtask

    task automatic test_replace_limit();
        logic [CP_BITS-1:0] limits[5];
        limits = '{21'h000000, 21'h00FFFC, 21'h00FFFF, 21'h10FFFF, 21'h1FFFFF};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            send_text('{8'h41, 8'hEF, 8'hBF, 8'hBD, 8'hEF, 8'hBF, 8'hBC, 8'hF0, 8'h90,
                        8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00});
        end
        settle();
    endtask

    task automatic test_random_text();
        int target;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0: write_limit(21'h10FFFF);
                1: write_limit(21'h00FFFF);
                2: write_limit(21'($urandom));
                default: write_limit(21'($urandom_range(32'h00FFFF, 32'h10FFFF)));
            endcase
            idle_on = (phase != 2 && phase != 5);
            target = bytes_taken + PHASE_BYTES;
            while (bytes_taken < target)
            begin
                send_random_string();
            end
        end
        idle_on = 1'b1;
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        text_byte = '0;
        out_stall = 1'b0;
        cont_left = '0;
        partial_cp = '0;
        char_total = '0;
        skip_to_nul = 1'b0;
        cp_limit = CP_LIMIT_RESET;
        idle_on = 1'b1;
        quiet = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        bytes_taken = 0;
        error_count = 0;
        chars_seen = 0;
        ends_seen = 0;
        bad_seen = 0;
        limits_written = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_legal_forms();
        test_error_forms();
        test_replace_limit();
        test_random_text();

        $display("Sent %0d bytes under %0d limit settings.", bytes_taken, limits_written);
        $display("Checked %0d codepoints, %0d string ends and %0d invalid strings.",
                 chars_seen, ends_seen, bad_seen);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
